FILE: design/swqt_pkg.sv
// Shared types and codes for the semaphore wait-queue table.
// Used by the table top level and the bench; no dependencies.
`default_nettype none
package swqt_pkg;

   localparam int MAX_PROCS_DEF = 32;

   typedef enum logic [1:0] {
      KIND_BLOCK  = 2'd0,
      KIND_WAKE   = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_PEEK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOFREE   = 2'd1,
      STAT_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_TRD,
      S_TWR,
      S_PWR,
      S_PRD,
      S_PCHK,
      S_DRD,
      S_DCHK,
      S_UNLINK,
      S_HRD,
      S_HWR,
      S_WRD,
      S_WCHK,
      S_PNRD,
      S_PNWR,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: design/swqt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module swqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

FILE: design/semaphore_wait_queue_table.sv
// Semaphore wait-queue table. One transaction in, one result out. A key lookup
// scans the descriptor memory one entry per cycle; removing a process that is
// not at the head walks its queue through the process memory, reading and then
// checking each link. A stalled result holds the block in its final state.
// Depends on swqt_pkg and swqt_ram.
`default_nettype none
module semaphore_wait_queue_table
   import swqt_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_sem_key,
   input  wire logic [4:0]  req_proc_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_result_proc,
   output logic             rsp_result_valid
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam int DW = 32 + 2 * IW;
   localparam int PW = 2 * IW;
   localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);

   state_type state_ff, state_in;

   logic [MAX_PROCS-1:0] active_ff, blocked_ff;
   kind_type             kind_ff;
   logic [31:0]          key_ff, dkey_ff;
   logic [IW-1:0]        p_ff, d_ff, head_ff, tail_ff, cur_ff, cdesc_ff, free_ff;
   logic [IW-1:0]        cmp_idx_ff, walk_ff;
   logic [IW:0]          scan_ff;
   logic                 cmp_vld_ff, free_vld_ff;
   status_type           status_ff;
   logic [IW-1:0]        rproc_ff;
   logic                 rvalid_ff;

   logic                 d_we, p_we;
   logic [IW-1:0]        d_waddr, d_raddr, p_waddr, p_raddr;
   logic [DW-1:0]        d_wdata, d_rdata;
   logic [PW-1:0]        p_wdata, p_rdata;

   logic                 accept, issue, scan_hit, scan_last, p_ok;
   logic [IW-1:0]        req_p, rd_head, rd_tail, rd_next, rd_desc;

   assign accept    = req_valid && !req_stall;
   assign req_p     = IW'(req_proc_id);
   assign p_ok      = 32'(req_proc_id) < 32'(MAX_PROCS);
   assign issue     = scan_ff < (IW + 1)'(MAX_PROCS);
   assign rd_head   = d_rdata[2*IW-1:IW];
   assign rd_tail   = d_rdata[IW-1:0];
   assign rd_next   = p_rdata[2*IW-1:IW];
   assign rd_desc   = p_rdata[IW-1:0];
   assign scan_hit  = cmp_vld_ff && active_ff[cmp_idx_ff] && d_rdata[DW-1:2*IW] == key_ff;
   assign scan_last = cmp_vld_ff && cmp_idx_ff == LAST;

   swqt_ram #(.WIDTH(DW), .DEPTH(MAX_PROCS)) u_desc_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   swqt_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_proc_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_BLOCK:
                     state_in = (req_sem_key == '0 || !p_ok || blocked_ff[req_p]) ?
                                S_DONE : S_SCAN;
                  KIND_REMOVE:
                     state_in = (!p_ok || !blocked_ff[req_p]) ? S_DONE : S_PRD;
                  KIND_WAKE, KIND_PEEK:
                     state_in = (req_sem_key == '0) ? S_DONE : S_SCAN;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               unique case (kind_ff)
                  KIND_BLOCK: state_in = S_TRD;
                  KIND_WAKE:  state_in = S_UNLINK;
                  default:    state_in = S_DONE;
               endcase
            end else if (scan_last) begin
               state_in = (kind_ff == KIND_BLOCK) ? S_ALLOC : S_DONE;
            end
         end
         S_ALLOC:  state_in = S_DONE;
         S_TRD:    state_in = S_TWR;
         S_TWR:    state_in = S_PWR;
         S_PWR:    state_in = S_DONE;
         S_PRD:    state_in = S_PCHK;
         S_PCHK:   state_in = active_ff[rd_desc] ? S_DRD : S_DONE;
         S_DRD:    state_in = S_DCHK;
         S_DCHK:   state_in = S_UNLINK;
         S_UNLINK: begin
            if (head_ff == p_ff) begin
               state_in = (tail_ff == p_ff) ? S_DONE : S_HRD;
            end else begin
               state_in = S_WRD;
            end
         end
         S_HRD:    state_in = S_HWR;
         S_HWR:    state_in = S_DONE;
         S_WRD:    state_in = S_WCHK;
         S_WCHK: begin
            priority if (rd_next == p_ff) begin
               state_in = S_PNRD;
            end else if (cur_ff == tail_ff || walk_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WRD;
            end
         end
         S_PNRD:   state_in = S_PNWR;
         S_PNWR:   state_in = S_DONE;
         S_DONE:   state_in = (!rsp_valid || !rsp_stall) ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory controls
   always_comb begin
      req_stall = reset || state_ff != S_IDLE;
      d_we      = 1'b0;
      d_waddr   = d_ff;
      d_wdata   = {dkey_ff, head_ff, tail_ff};
      d_raddr   = d_ff;
      p_we      = 1'b0;
      p_waddr   = p_ff;
      p_wdata   = {p_ff, d_ff};
      p_raddr   = p_ff;
      unique case (state_ff)
         S_SCAN: d_raddr = scan_ff[IW-1:0];
         S_ALLOC: begin
            if (free_vld_ff) begin
               d_we    = 1'b1;
               d_waddr = free_ff;
               d_wdata = {key_ff, p_ff, p_ff};
               p_we    = 1'b1;
               p_wdata = {p_ff, free_ff};
            end
         end
         S_TRD: p_raddr = tail_ff;
         S_TWR: begin
            // link the new process behind the old tail
            p_we    = 1'b1;
            p_waddr = tail_ff;
            p_wdata = {p_ff, rd_desc};
            d_we    = 1'b1;
            d_wdata = {key_ff, head_ff, p_ff};
         end
         S_PWR: p_we = 1'b1;
         S_WRD: p_raddr = cur_ff;
         S_HWR: begin
            d_we    = 1'b1;
            d_wdata = {dkey_ff, rd_next, tail_ff};
         end
         S_PNWR: begin
            // bypass the removed process
            p_we    = 1'b1;
            p_waddr = cur_ff;
            p_wdata = {rd_next, cdesc_ff};
            if (tail_ff == p_ff) begin
               d_we    = 1'b1;
               d_wdata = {dkey_ff, head_ff, cur_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= '0;
         blocked_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // load a new result, else drop the one just taken
         if (state_ff == S_DONE && (!rsp_valid || !rsp_stall)) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            S_ALLOC: begin
               if (free_vld_ff) begin
                  active_ff[free_ff] <= 1'b1;
                  blocked_ff[p_ff]   <= 1'b1;
               end
            end
            S_PWR: blocked_ff[p_ff] <= 1'b1;
            S_UNLINK: begin
               blocked_ff[p_ff] <= 1'b0;
               if (head_ff == p_ff && tail_ff == p_ff) begin
                  active_ff[d_ff] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            kind_ff     <= kind_type'(req_kind);
            key_ff      <= req_sem_key;
            p_ff        <= req_p;
            scan_ff     <= '0;
            cmp_vld_ff  <= 1'b0;
            free_vld_ff <= 1'b0;
            status_ff   <= STAT_NOTFOUND;
            rproc_ff    <= '0;
            rvalid_ff   <= 1'b0;
         end
         S_SCAN: begin
            scan_ff    <= scan_ff + 1'b1;
            cmp_vld_ff <= issue;
            cmp_idx_ff <= scan_ff[IW-1:0];
            if (cmp_vld_ff && !active_ff[cmp_idx_ff] && !free_vld_ff) begin
               free_vld_ff <= 1'b1;
               free_ff     <= cmp_idx_ff;
            end
            if (scan_hit) begin
               d_ff    <= cmp_idx_ff;
               dkey_ff <= key_ff;
               head_ff <= rd_head;
               tail_ff <= rd_tail;
               if (kind_ff != KIND_BLOCK) begin
                  p_ff      <= rd_head;
                  rproc_ff  <= rd_head;
                  rvalid_ff <= 1'b1;
                  status_ff <= STAT_OK;
               end
            end
         end
         S_ALLOC: status_ff <= free_vld_ff ? STAT_OK : STAT_NOFREE;
         S_PWR:   status_ff <= STAT_OK;
         S_PCHK:  d_ff <= rd_desc;
         S_DCHK: begin
            dkey_ff   <= d_rdata[DW-1:2*IW];
            head_ff   <= rd_head;
            tail_ff   <= rd_tail;
            rproc_ff  <= p_ff;
            rvalid_ff <= 1'b1;
            status_ff <= STAT_OK;
         end
         S_UNLINK: begin
            cur_ff  <= head_ff;
            walk_ff <= '0;
         end
         S_WCHK: begin
            cdesc_ff <= rd_desc;
            if (rd_next != p_ff) begin
               cur_ff  <= rd_next;
               walk_ff <= walk_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid || !rsp_stall) begin
               rsp_status       <= status_ff;
               rsp_result_proc  <= 5'(rproc_ff);
               rsp_result_valid <= rvalid_ff;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for semaphore_wait_queue_table: directed table, then random traffic.
// Predicts each result with its own wait-queue model; depends on swqt_pkg and the block.
`timescale 1ns / 1ps
module tb;
   import swqt_pkg::*;

   localparam int NPROC = 32;
   localparam int KEYS_NUM = 6;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] key;
      logic [4:0]  pid;
      logic        chk;
      status_type  st;
      logic [4:0]  rp;
      logic        rv;
   } row_type;

   typedef struct packed {
      status_type st;
      logic [4:0] rp;
      logic       rv;
   } wake_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [31:0] req_sem_key = '0;
   logic [4:0] req_proc_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [4:0] rsp_result_proc;
   logic rsp_result_valid;

   semaphore_wait_queue_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_sem_key(req_sem_key), .req_proc_id(req_proc_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_result_proc(rsp_result_proc),
      .rsp_result_valid(rsp_result_valid)
   );

   always #4 clock = ~clock;

   // predictor state: per-key FIFO of process ids
   logic [31:0] q_key [NPROC];
   logic        q_used [NPROC];
   int          q_fifo [NPROC][$];
   logic        blocked [NPROC];

   wake_res_type expected_q [$];
   int errors = 0;
   logic quiet = 1'b1;
   logic hold_off = 1'b0;
   logic [31:0] key_pool [KEYS_NUM];

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int find_queue(input logic [31:0] key);
      if (key == 0) return -1;
      for (int d = 0; d < NPROC; d++)
         if (q_used[d] && q_key[d] == key) return d;
      return -1;
   endfunction

   function automatic wake_res_type predict_op(input kind_type k, input logic [31:0] key,
                                               input logic [4:0] p);
      wake_res_type r;
      int d;
      r = '{STAT_NOTFOUND, 5'd0, 1'b0};
      case (k)
         KIND_BLOCK: begin
            if (key != 0 && !blocked[p]) begin
               d = find_queue(key);
               if (d < 0) begin
                  for (int i = 0; i < NPROC; i++)
                     if (!q_used[i]) begin d = i; break; end
                  if (d >= 0) begin
                     q_used[d] = 1'b1;
                     q_key[d] = key;
                     q_fifo[d].delete();
                  end
               end
               if (d < 0) r.st = STAT_NOFREE;
               else begin
                  q_fifo[d].push_back(int'(p));
                  blocked[p] = 1'b1;
                  r.st = STAT_OK;
               end
            end
         end
         KIND_WAKE, KIND_PEEK: begin
            d = find_queue(key);
            if (d >= 0) begin
               r = '{STAT_OK, 5'(q_fifo[d][0]), 1'b1};
               if (k == KIND_WAKE) begin
                  blocked[q_fifo[d][0]] = 1'b0;
                  void'(q_fifo[d].pop_front());
                  if (q_fifo[d].size() == 0) q_used[d] = 1'b0;
               end
            end
         end
         default: begin
            if (blocked[p]) begin
               for (int i = 0; i < NPROC; i++)
                  if (q_used[i])
                     for (int j = 0; j < q_fifo[i].size(); j++)
                        if (q_fifo[i][j] == int'(p)) begin
                           q_fifo[i].delete(j);
                           if (q_fifo[i].size() == 0) q_used[i] = 1'b0;
                           break;
                        end
               blocked[p] = 1'b0;
               r = '{STAT_OK, p, 1'b1};
            end
         end
      endcase
      return r;
   endfunction

   // drive one transaction and hold it until accepted
   task automatic send(input row_type t);
      wake_res_type r;
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= t.kind;
      req_sem_key <= t.key;
      req_proc_id <= t.pid;
      r = predict_op(t.kind, t.key, t.pid);
      if (t.chk && r != {t.st, t.rp, t.rv})
         report("table row", int'(r), int'({t.st, t.rp, t.rv}));
      expected_q.push_back(r);
      do @(posedge clock); while (req_stall);
   endtask

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= !quiet && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      wake_res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) report("unexpected result", int'(rsp_status), -1);
         else begin
            e = expected_q.pop_front();
            if (rsp_status != e.st) report("status", int'(rsp_status), int'(e.st));
            if (rsp_result_proc != e.rp)
               report("result_proc", int'(rsp_result_proc), int'(e.rp));
            if (rsp_result_valid != e.rv)
               report("result_valid", int'(rsp_result_valid), int'(e.rv));
         end
      end
   end

   function automatic row_type mk(input kind_type k, input logic [31:0] key,
                                  input logic [4:0] p);
      return '{k, key, p, 1'b0, STAT_OK, 5'd0, 1'b0};
   endfunction

   function automatic row_type mkc(input kind_type k, input logic [31:0] key, input logic [4:0] p,
                                   input status_type s, input logic [4:0] rp, input logic rv);
      return '{k, key, p, 1'b1, s, rp, rv};
   endfunction

   function automatic row_type rand_item();
      row_type t;
      int sel;
      sel = $urandom_range(99);
      t = mk(kind_type'($urandom_range(3)), key_pool[$urandom_range(KEYS_NUM - 1)],
             5'($urandom_range(NPROC - 1)));
      if (sel < 3) t.key = $urandom;
      else if (sel < 5) t.key = 0;
      else if (sel < 45) t.kind = KIND_BLOCK;
      return t;
   endfunction

   initial begin
      row_type dir [$];
      int hold;
      for (int d = 0; d < NPROC; d++) begin
         q_used[d] = 1'b0;
         blocked[d] = 1'b0;
      end
      key_pool = '{32'd1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0000_1000, 32'h8000_0000};
      dir = '{
         mkc(KIND_WAKE, 32'd1, 5'd0, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_PEEK, 32'hFFFF_FFFF, 5'd0, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_REMOVE, 32'd0, 5'd31, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'd0, 5'd3, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'd1, 5'd0, STAT_OK, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'd1, 5'd31, STAT_OK, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'hFFFF_FFFF, 5'd31, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'd1, 5'd7, STAT_OK, 5'd0, 1'b0),
         mkc(KIND_PEEK, 32'd1, 5'd0, STAT_OK, 5'd0, 1'b1),
         mkc(KIND_REMOVE, 32'd0, 5'd31, STAT_OK, 5'd31, 1'b1),
         mkc(KIND_REMOVE, 32'd0, 5'd7, STAT_OK, 5'd7, 1'b1),
         mkc(KIND_PEEK, 32'd0, 5'd0, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_BLOCK, 32'hFFFF_FFFF, 5'd5, STAT_OK, 5'd0, 1'b0),
         mkc(KIND_WAKE, 32'd1, 5'd0, STAT_OK, 5'd0, 1'b1),
         mkc(KIND_WAKE, 32'd1, 5'd0, STAT_NOTFOUND, 5'd0, 1'b0),
         mkc(KIND_REMOVE, 32'd0, 5'd5, STAT_OK, 5'd5, 1'b1),
         mkc(KIND_REMOVE, 32'd0, 5'd5, STAT_NOTFOUND, 5'd0, 1'b0)
      };
      // fill every descriptor with a distinct key; a further key is refused
      // because its process is already blocked
      for (int i = 0; i < NPROC; i++) dir.push_back(mk(KIND_BLOCK, 32'(i + 100), 5'(i)));
      for (int i = 0; i < NPROC; i++) begin
         dir.push_back(mk(KIND_PEEK, 32'(i + 100), 5'd0));
         if (i == 0) begin
            dir.push_back(mkc(KIND_REMOVE, 32'd0, 5'd0, STAT_OK, 5'd0, 1'b1));
            dir.push_back(mkc(KIND_BLOCK, 32'hDEAD_BEEF, 5'd0, STAT_OK, 5'd0, 1'b0));
            dir.push_back(mkc(KIND_BLOCK, 32'h1234_5678, 5'd0, STAT_NOTFOUND, 5'd0, 1'b0));
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir[i]) send(dir[i]);
      // a full pool: wake the filler so random keys reuse descriptors
      for (int i = 1; i < NPROC; i++) send(mk(KIND_WAKE, 32'(i + 100), 5'd0));
      send(mk(KIND_WAKE, 32'hDEAD_BEEF, 5'd0));
      quiet = 1'b0;
      for (int n = 0; n < 1000; n++) begin
         if (n == 300) begin
            // long receiver hold-off while requests keep coming
            hold_off = 1'b1;
            fork
               begin
                  hold = 0;
                  while (hold < 600) begin @(posedge clock); hold++; end
                  hold_off = 1'b0;
               end
            join_none
         end
         if (n == 600) begin
            req_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         if (n == 700) quiet = 1'b1;
         if (n == 800) quiet = 1'b0;
         send(rand_item());
      end
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
